[sv/three_dye_least_squares_fit_defines.svh]
// assertion macros used by the checker file
`ifndef THREE_DYE_LEAST_SQUARES_FIT_DEFINES_SVH
`define THREE_DYE_LEAST_SQUARES_FIT_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define TDLSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TDLSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tdlsf_pkg.sv]
// shared constants and controller/datapath interface types
package tdlsf_pkg;

  localparam int W               = 48;
  localparam int EPS_W           = 16;
  localparam int THR_W           = 40;
  localparam int AMT_W           = 15;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 12;

  localparam logic [W-1:0]     WLIM      = {1'b0, {(W-1){1'b1}}};
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef struct packed {
    logic       acc;
    logic       load;
    logic       pivot;
    logic       div_start;
    logic       fcap;
    logic       mul_start;
    logic       emit;
    logic       emit_ok;
    logic [1:0] i;
    logic [1:0] r;
    logic [1:0] c;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic singular;
    logic div_done;
    logic mul_done;
    logic out_busy;
  } status_t;

endpackage

[sv/three_dye_least_squares_fit.sv]
// three-dye least-squares fit: one sample per cycle accumulation, then a 3x3 solve
// a sample is taken every cycle while the block is idle; after the last one the solve time
//   is set by the bit-serial divider (one quotient bit per cycle) and the four-step
//   multiplier
// a result waits in an output register while the next run is accumulated
// reset: asynchronous active low, sums and count cleared, threshold set to 1
module three_dye_least_squares_fit #(
  parameter int MAX_SAMPLES = tdlsf_pkg::MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = tdlsf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tdlsf_pkg::THR_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // eps_yellow [15:0], eps_magenta [31:16], eps_cyan [47:32], base_density [63:48]
  input  logic [63:0]                 s_axis_tdata,
  // sample_invalid [0]
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // amount_yellow [14:0], amount_magenta [29:15], amount_cyan [44:30], zero [47:45]
  output logic [47:0]                 m_axis_tdata,
  // fit_status [0]
  output logic                        m_axis_tuser
);
  import tdlsf_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [AMT_W-1:0] amt_y, amt_m, amt_c;

  tdlsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tdlsf_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .eps_yellow_i     (s_axis_tdata[15:0]),
    .eps_magenta_i    (s_axis_tdata[31:16]),
    .eps_cyan_i       (s_axis_tdata[47:32]),
    .base_density_i   (s_axis_tdata[63:48]),
    .sample_invalid_i (s_axis_tuser),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .amount_yellow_o  (amt_y),
    .amount_magenta_o (amt_m),
    .amount_cyan_o    (amt_c),
    .fit_status_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, amt_c, amt_m, amt_y};

endmodule

[sv/tdlsf_div.sv]
// bit-serial signed fixed-point divider: (x << frac) / d, saturated
module tdlsf_div #(
  parameter int NW = 72
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [tdlsf_pkg::W-1:0] x_i,
  input  logic signed [tdlsf_pkg::W-1:0] d_i,
  output logic                          done_o,
  output logic signed [tdlsf_pkg::W-1:0] q_o
);
  import tdlsf_pkg::*;

  localparam int WF = NW - W;
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  num_q;
  logic [W-1:0]   dm_q, quo_q, mag_sat;
  logic [W:0]     rem_q, rem_sh;
  logic           neg_q, ovf_q, busy_q, done_q, ge;
  logic [CNW-1:0] cnt_q;
  logic [W-1:0]   x_mag, d_mag;

  assign x_mag  = x_i[W-1] ? W'(-x_i) : W'(x_i);
  assign d_mag  = d_i[W-1] ? W'(-d_i) : W'(d_i);
  assign rem_sh = {rem_q[W-1:0], num_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {x_mag, {WF{1'b0}}};
      dm_q  <= d_mag;
      neg_q <= x_i[W-1] ^ d_i[W-1];
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= ge ? rem_sh - {1'b0, dm_q} : rem_sh;
      quo_q <= {quo_q[W-2:0], ge};
      ovf_q <= ovf_q | quo_q[W-1];
    end
  end

  assign mag_sat = (ovf_q || quo_q[W-1]) ? WLIM : quo_q;
  assign q_o     = neg_q ? -$signed(mag_sat) : $signed(mag_sat);
  assign done_o  = done_q;

endmodule

[sv/tdlsf_mul.sv]
// multi-cycle signed fixed-point multiplier: (a * b) >> frac, saturated
module tdlsf_mul #(
  parameter int WF = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [tdlsf_pkg::W-1:0] a_i,
  input  logic signed [tdlsf_pkg::W-1:0] b_i,
  output logic                          done_o,
  output logic signed [tdlsf_pkg::W-1:0] p_o
);
  import tdlsf_pkg::*;

  localparam int H = W / 2;

  logic [W-1:0]   a_q, b_q, mag;
  logic [2*W-1:0] acc_q, pp_ext, prod_sh;
  logic [H-1:0]   pa, pb;
  logic [2*H-1:0] pp;
  logic [1:0]     k_q;
  logic           neg_q, busy_q, done_q;

  // one half-width partial product per cycle
  assign pa = k_q[1] ? a_q[W-1:H] : a_q[H-1:0];
  assign pb = k_q[0] ? b_q[W-1:H] : b_q[H-1:0];
  assign pp = pa * pb;

  always_comb begin
    pp_ext = (2*W)'(pp);
    case (k_q)
      2'd0:    pp_ext = (2*W)'(pp);
      2'd3:    pp_ext = (2*W)'(pp) << (2*H);
      default: pp_ext = (2*W)'(pp) << H;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i[W-1] ? W'(-a_i) : W'(a_i);
      b_q   <= b_i[W-1] ? W'(-b_i) : W'(b_i);
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_ext;
    end
  end

  assign prod_sh = acc_q >> WF;
  assign mag     = (prod_sh > (2*W)'(WLIM)) ? WLIM : prod_sh[W-1:0];
  assign p_o     = neg_q ? -$signed(mag) : $signed(mag);
  assign done_o  = done_q;

endmodule

[sv/tdlsf_dp.sv]
// datapath: sums, working matrix, shared divider and multiplier, result register
module tdlsf_dp #(
  parameter int MAX_SAMPLES = tdlsf_pkg::MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = tdlsf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdlsf_pkg::cmd_t                   cmd_i,
  output tdlsf_pkg::status_t                status_o,
  input  logic                              cfg_we_i,
  input  logic [tdlsf_pkg::THR_W-1:0]       cfg_wdata_i,
  input  logic signed [tdlsf_pkg::EPS_W-1:0] eps_yellow_i,
  input  logic signed [tdlsf_pkg::EPS_W-1:0] eps_magenta_i,
  input  logic signed [tdlsf_pkg::EPS_W-1:0] eps_cyan_i,
  input  logic signed [tdlsf_pkg::EPS_W-1:0] base_density_i,
  input  logic                              sample_invalid_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tdlsf_pkg::AMT_W-1:0]       amount_yellow_o,
  output logic [tdlsf_pkg::AMT_W-1:0]       amount_magenta_o,
  output logic [tdlsf_pkg::AMT_W-1:0]       amount_cyan_o,
  output logic                              fit_status_o
);
  import tdlsf_pkg::*;

  localparam int WF = 2 * FRAC_BITS;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = 2 * EPS_W;
  localparam logic signed [W:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0] NEG_LIM = -POS_LIM;

  logic signed [W-1:0] sum_q [6];
  logic signed [W-1:0] sum_d [6];
  logic signed [W-1:0] rhs_q [3];
  logic signed [W-1:0] rhs_d [3];
  logic signed [PW-1:0] prod [9];
  logic [CW-1:0]       count_q, count_d;
  logic                take, empty_q;
  logic [THR_W-1:0]    thr_q;

  logic signed [W-1:0] m_q [3][4];
  logic signed [W-1:0] piv_q, f_q, div_q, mul_p;
  logic                div_done, mul_done;
  logic [1:0]          p_row;
  logic [W-1:0]        best, cand;
  logic                singular;
  logic signed [W:0]   diff;
  logic signed [W-1:0] diff_sat;

  logic                out_valid_q, fit_status_q;
  logic [AMT_W-1:0]    amt_q [3];

  function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] v);
    mag_of = v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic [AMT_W-1:0] amount_of(input logic signed [W-1:0] v);
    logic [W-1:0] sh;
    sh = W'(v) >> FRAC_BITS;
    if (v <= 0) begin
      amount_of = '0;
    end else if (sh > W'({AMT_W{1'b1}})) begin
      amount_of = {AMT_W{1'b1}};
    end else begin
      amount_of = sh[AMT_W-1:0];
    end
  endfunction

  // per-sample products for the normal matrix and right-hand side
  assign prod[0] = eps_yellow_i  * eps_yellow_i;
  assign prod[1] = eps_yellow_i  * eps_magenta_i;
  assign prod[2] = eps_yellow_i  * eps_cyan_i;
  assign prod[3] = eps_magenta_i * eps_magenta_i;
  assign prod[4] = eps_magenta_i * eps_cyan_i;
  assign prod[5] = eps_cyan_i    * eps_cyan_i;
  assign prod[6] = eps_yellow_i  * base_density_i;
  assign prod[7] = eps_magenta_i * base_density_i;
  assign prod[8] = eps_cyan_i    * base_density_i;

  assign take = cmd_i.acc && !sample_invalid_i && (count_q < CW'(MAX_SAMPLES));

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sum_d[k] = take ? sum_q[k] + W'(prod[k]) : sum_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      rhs_d[k] = take ? rhs_q[k] + W'(prod[k+6]) : rhs_q[k];
    end
    count_d = take ? count_q + 1'b1 : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) sum_q[k] <= '0;
      for (int k = 0; k < 3; k++) rhs_q[k] <= '0;
      count_q <= '0;
      empty_q <= 1'b0;
      thr_q   <= THR_RESET;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        for (int k = 0; k < 6; k++) sum_q[k] <= '0;
        for (int k = 0; k < 3; k++) rhs_q[k] <= '0;
        count_q <= '0;
        empty_q <= (count_d == '0);
      end else begin
        for (int k = 0; k < 6; k++) sum_q[k] <= sum_d[k];
        for (int k = 0; k < 3; k++) rhs_q[k] <= rhs_d[k];
        count_q <= count_d;
      end
    end
  end

  // partial pivot search, lowest row wins a tie
  always_comb begin
    p_row = cmd_i.i;
    best  = mag_of(m_q[cmd_i.i][cmd_i.i]);
    cand  = '0;
    for (int k = 1; k < 3; k++) begin
      cand = mag_of(m_q[k][cmd_i.i]);
      if (2'(k) > cmd_i.i && cand > best) begin
        best  = cand;
        p_row = 2'(k);
      end
    end
    singular = (best == '0) || (best < W'(thr_q));
  end

  tdlsf_div #(.NW(W + WF)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .x_i     (m_q[cmd_i.i][cmd_i.c]),
    .d_i     (piv_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  tdlsf_mul #(.WF(WF)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (f_q),
    .b_i     (m_q[cmd_i.i][cmd_i.c]),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_comb begin
    diff = {m_q[cmd_i.r][cmd_i.c][W-1], m_q[cmd_i.r][cmd_i.c]} - {mul_p[W-1], mul_p};
    if (diff > POS_LIM) begin
      diff_sat = W'(POS_LIM);
    end else if (diff < NEG_LIM) begin
      diff_sat = W'(NEG_LIM);
    end else begin
      diff_sat = diff[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q[0][0] <= sum_d[0];
      m_q[0][1] <= sum_d[1];
      m_q[0][2] <= sum_d[2];
      m_q[1][0] <= sum_d[1];
      m_q[1][1] <= sum_d[3];
      m_q[1][2] <= sum_d[4];
      m_q[2][0] <= sum_d[2];
      m_q[2][1] <= sum_d[4];
      m_q[2][2] <= sum_d[5];
      for (int k = 0; k < 3; k++) m_q[k][3] <= rhs_d[k];
    end else if (cmd_i.pivot) begin
      if (p_row != cmd_i.i) begin
        for (int c = 0; c < 4; c++) begin
          m_q[cmd_i.i][c] <= m_q[p_row][c];
          m_q[p_row][c]   <= m_q[cmd_i.i][c];
        end
      end
      piv_q <= m_q[p_row][cmd_i.i];
    end else if (div_done) begin
      m_q[cmd_i.i][cmd_i.c] <= div_q;
    end else if (mul_done) begin
      m_q[cmd_i.r][cmd_i.c] <= diff_sat;
    end
    if (cmd_i.fcap) f_q <= m_q[cmd_i.r][cmd_i.i];
  end

  // result register, so accumulation can go on while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fit_status_q <= !cmd_i.emit_ok;
      for (int k = 0; k < 3; k++) begin
        amt_q[k] <= cmd_i.emit_ok ? amount_of(m_q[k][3]) : '0;
      end
    end
  end

  assign status_o.empty    = empty_q;
  assign status_o.singular = singular;
  assign status_o.div_done = div_done;
  assign status_o.mul_done = mul_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign amount_yellow_o  = amt_q[0];
  assign amount_magenta_o = amt_q[1];
  assign amount_cyan_o    = amt_q[2];
  assign fit_status_o     = fit_status_q;

endmodule

[sv/tdlsf_ctrl.sv]
// controller: accumulation handshake and gauss-jordan solve sequencing
module tdlsf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  tdlsf_pkg::status_t status_i,
  output tdlsf_pkg::cmd_t    cmd_o
);
  import tdlsf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PIVOT = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_DIVW  = 8'b0000_1000,
    S_FCAP  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_MULW  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] i_q, i_d, r_q, r_d, c_q, c_d;
  logic       ok_q, ok_d;
  logic [2:0] rn;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    r_d     = r_q;
    c_d     = c_q;
    ok_d    = ok_q;
    cmd_o   = '0;
    cmd_o.i = i_q;
    cmd_o.r = r_q;
    cmd_o.c = c_q;
    in_ready_o = (state_q == S_IDLE);
    // next row to eliminate, skipping the pivot row
    rn = {1'b0, r_q} + 3'd1;
    if (rn[1:0] == i_q && rn < 3'd3) rn = {1'b0, r_q} + 3'd2;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) begin
            cmd_o.load = 1'b1;
            i_d        = '0;
            ok_d       = 1'b0;
            state_d    = S_PIVOT;
          end
        end
      end
      S_PIVOT: begin
        if (status_i.empty || status_i.singular) begin
          ok_d    = 1'b0;
          state_d = S_EMIT;
        end else begin
          cmd_o.pivot = 1'b1;
          c_d         = i_q;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (status_i.div_done) begin
          if (c_q == 2'd3) begin
            r_d     = (i_q == 2'd0) ? 2'd1 : 2'd0;
            state_d = S_FCAP;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_DIV;
          end
        end
      end
      S_FCAP: begin
        cmd_o.fcap = 1'b1;
        c_d        = i_q;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MULW;
      end
      S_MULW: begin
        if (status_i.mul_done) begin
          if (c_q != 2'd3) begin
            c_d     = c_q + 1'b1;
            state_d = S_MUL;
          end else if (rn < 3'd3) begin
            r_d     = rn[1:0];
            state_d = S_FCAP;
          end else if (i_q == 2'd2) begin
            ok_d    = 1'b1;
            state_d = S_EMIT;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_PIVOT;
          end
        end
      end
      S_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit    = 1'b1;
          cmd_o.emit_ok = ok_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      r_q     <= '0;
      c_q     <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      r_q     <= r_d;
      c_q     <= c_d;
      ok_q    <= ok_d;
    end
  end

endmodule

[sv/tdlsf_checker.sv]
// port-level checker for the fit block, bound to the top level
`include "three_dye_least_squares_fit_defines.svh"

module tdlsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result transaction keeps its payload
  `TDLSF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // singular or empty status carries zero amounts
  `TDLSF_ASSERT(a_fail_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 48'd0), "nonzero amounts with singular status")

  // the solve starts right after the last sample and blocks input
  `TDLSF_ASSERT_NEXT(a_solve_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during solve")

endmodule

bind three_dye_least_squares_fit tdlsf_checker u_tdlsf_checker (.*);
